FILE: rtl/core/assert_macros.svh
// assertion macros shared by the crossover rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define OCX_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define OCX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ocx_pkg.sv
// shared types and constants for the order crossover unit
// no dependencies; used by every rtl module of the block
package ocx_pkg;

  localparam int CITY_W         = 6;
  localparam int CITY_COUNT     = 64;
  localparam int MAX_CITIES_DEF = 64;
  // width that holds cut points, counts and their sums without overflow
  localparam int EXT_W          = CITY_W + 2;

  // one input item
  typedef struct packed {
    logic [CITY_W-1:0] first_parent_city;
    logic [CITY_W-1:0] second_parent_city;
    logic [CITY_W-1:0] cut_start;
    logic [CITY_W-1:0] cut_end;
    logic              last;
  } ocx_in_t;

  // one result item
  typedef struct packed {
    logic [CITY_W-1:0] child_city;
    logic              unfilled;
    logic              bad_cut;
    logic              last_res;
  } ocx_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic run;
    logic copy;
    logic scan;
    logic flush;
    logic emit;
  } ocx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic copy_end;
    logic scan_end;
    logic out_end;
    logic bad;
  } ocx_stat_t;

endpackage

FILE: rtl/core/order_crossover_permutation_unit.sv
// top level of the order crossover unit: sequencer plus datapath
// depends on ocx_pkg, ocx_ctrl, ocx_dpath and assert_macros.svh
//
// Each item loads one position of both parents and is taken in the cycle
// that start is high while busy is low. The item with last set closes the
// tour of n cities and supplies the cuts; busy then stays high while the
// parent and child memories are walked one entry per cycle: copy of the
// kept segment (all of parent one with bad cuts, and then no scan), scan
// of parent two, a flush state, then the child sweep.
// The n results come on consecutive cycles, each shown for exactly one
// cycle with result_valid high, and must be taken as they come; the
// last one carries last_res and falls in the final busy cycle.
`include "assert_macros.svh"
module order_crossover_permutation_unit #(
  parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ocx_pkg::ocx_in_t  item,
  output ocx_pkg::ocx_out_t result,
  output logic             result_valid
);
  import ocx_pkg::*;

  ocx_cmd_t  cmd;
  ocx_stat_t stat;

  // sequencer
  ocx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (item.last),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath
  ocx_dpath #(
    .MAX_CITIES (MAX_CITIES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

  `OCX_ASSERT_IMPL(a_res_busy, clk, rst, result_valid, busy, "result strobe while idle")
  `OCX_ASSERT_NEXT(a_last_gap, clk, rst, result_valid && result.last_res, !result_valid, "result after final item")

endmodule

FILE: rtl/core/ocx_ctrl.sv
// phase sequencer for the order crossover unit
// depends on ocx_pkg
module ocx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last,
  input  ocx_pkg::ocx_stat_t stat,
  output ocx_pkg::ocx_cmd_t  cmd,
  output logic              busy
);
  import ocx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_SCAN,
    S_FLUSH,
    S_OUT,
    S_TAIL
  } state_t;

  state_t state;

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && last) begin
            state <= S_COPY;
            busy  <= 1'b1;
          end
        end
        S_COPY: begin
          if (stat.copy_end) begin
            state <= stat.bad ? S_FLUSH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_end) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (stat.out_end) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd       = '0;
    cmd.load  = start && !busy;
    cmd.run   = start && !busy && last;
    cmd.copy  = (state == S_COPY);
    cmd.scan  = (state == S_SCAN);
    cmd.flush = (state == S_FLUSH);
    cmd.emit  = (state == S_OUT);
  end

endmodule

FILE: rtl/core/ocx_dpath.sv
// parent and child memories, visit map, indexes and output stage
// depends on ocx_pkg and assert_macros.svh
`include "assert_macros.svh"
module ocx_dpath #(
  parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ocx_pkg::ocx_in_t   item,
  input  ocx_pkg::ocx_cmd_t  cmd,
  output ocx_pkg::ocx_stat_t stat,
  output ocx_pkg::ocx_out_t  result,
  output logic              result_valid
);
  import ocx_pkg::*;

  localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int NW = $clog2(MAX_CITIES + 1);

  // memories
  logic [CITY_W-1:0] p1_mem [MAX_CITIES];
  logic [CITY_W-1:0] p2_mem [MAX_CITIES];
  logic [CITY_W-1:0] child_mem [MAX_CITIES];
  logic [CITY_W-1:0] p1_rd;
  logic [CITY_W-1:0] p2_rd;
  logic [CITY_W-1:0] ch_rd;

  // run state
  logic [NW-1:0]         load_count;
  logic [AW-1:0]         n_m1;
  logic [AW-1:0]         copy_last;
  logic                  bad;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         ppos;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         scan_cnt;
  logic [NW-1:0]         k;
  logic [NW-1:0]         slots;
  logic [MAX_CITIES-1:0] child_filled;
  logic [CITY_COUNT-1:0] visited_map;

  // write stage and output stage
  logic          cp_valid;
  logic [AW-1:0] cp_addr;
  logic          sc_valid;
  logic          emit_valid;
  logic          emit_last;
  logic          emit_filled;

  // run setup from the last item
  logic             store;
  logic [NW-1:0]    n_now;
  logic [EXT_W-1:0] cs_e;
  logic [EXT_W-1:0] ce_e;
  logic [EXT_W-1:0] n_e;
  logic [EXT_W-1:0] nm1_e;
  logic [EXT_W-1:0] wrap_e;
  logic [EXT_W-1:0] slots_e;
  logic             bad_now;

  always_comb begin
    store   = (load_count < NW'(MAX_CITIES));
    n_now   = load_count + NW'(store);
    cs_e    = EXT_W'(item.cut_start);
    ce_e    = EXT_W'(item.cut_end);
    n_e     = EXT_W'(n_now);
    nm1_e   = n_e - EXT_W'(1);
    wrap_e  = ((ce_e + EXT_W'(1)) == n_e) ? '0 : (ce_e + EXT_W'(1));
    slots_e = n_e - (ce_e - cs_e) - EXT_W'(1);
    bad_now = !((cs_e < ce_e) && (ce_e < n_e));
  end

  // child write port, shared by the copy and the scan
  logic              sc_take;
  logic              ch_we;
  logic [AW-1:0]     ch_waddr;
  logic [CITY_W-1:0] ch_wdata;

  always_comb begin
    sc_take  = sc_valid && !visited_map[p2_rd] && (k < slots);
    ch_we    = cp_valid || sc_take;
    ch_waddr = cp_valid ? cp_addr : pos;
    ch_wdata = cp_valid ? p1_rd : p2_rd;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.load && store) begin
      p1_mem[load_count[AW-1:0]] <= item.first_parent_city;
      p2_mem[load_count[AW-1:0]] <= item.second_parent_city;
    end
    if (ch_we) begin
      child_mem[ch_waddr] <= ch_wdata;
    end
    p1_rd <= p1_mem[idx];
    p2_rd <= p2_mem[ppos];
    ch_rd <= child_mem[idx];
  end

  // indexes, maps and stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      bad          <= 1'b0;
      k            <= '0;
      slots        <= '0;
      child_filled <= '0;
      visited_map  <= '0;
      cp_valid     <= 1'b0;
      sc_valid     <= 1'b0;
      emit_valid   <= 1'b0;
      emit_last    <= 1'b0;
    end else begin
      cp_valid   <= cmd.copy;
      sc_valid   <= cmd.scan;
      emit_valid <= cmd.emit;
      emit_last  <= cmd.emit && (idx == n_m1);

      // loading
      if (cmd.run) begin
        load_count   <= '0;
        n_m1         <= AW'(nm1_e);
        bad          <= bad_now;
        copy_last    <= bad_now ? AW'(nm1_e) : AW'(ce_e);
        idx          <= bad_now ? '0 : AW'(cs_e);
        ppos         <= AW'(wrap_e);
        pos          <= AW'(wrap_e);
        scan_cnt     <= '0;
        k            <= '0;
        slots        <= NW'(slots_e);
        child_filled <= '0;
        visited_map  <= '0;
      end else if (cmd.load && store) begin
        load_count <= load_count + NW'(1);
      end

      // copy of the kept segment
      if (cmd.copy) begin
        cp_addr <= idx;
        idx     <= idx + AW'(1);
      end
      if (cp_valid) begin
        child_filled[cp_addr] <= 1'b1;
        if (!bad) begin
          visited_map[p1_rd] <= 1'b1;
        end
      end

      // cyclic scan of parent two
      if (cmd.scan) begin
        ppos     <= (ppos == n_m1) ? '0 : ppos + AW'(1);
        scan_cnt <= scan_cnt + AW'(1);
      end
      if (sc_take) begin
        child_filled[pos] <= 1'b1;
        k                 <= k + NW'(1);
        pos               <= (pos == n_m1) ? '0 : pos + AW'(1);
      end

      // output sweep
      if (cmd.flush) begin
        idx <= '0;
      end
      if (cmd.emit) begin
        emit_filled <= child_filled[idx];
        idx         <= idx + AW'(1);
      end
    end
  end

  // status
  always_comb begin
    stat          = '0;
    stat.copy_end = (idx == copy_last);
    stat.scan_end = (scan_cnt == n_m1);
    stat.out_end  = (idx == n_m1);
    stat.bad      = bad;
  end

  // result
  always_comb begin
    result            = '0;
    result.child_city = emit_filled ? ch_rd : '0;
    result.unfilled   = !emit_filled;
    result.bad_cut    = bad;
    result.last_res   = emit_last;
    result_valid      = emit_valid;
  end

  `OCX_ASSERT_IMPL(a_wr_excl, clk, rst, cp_valid, !sc_valid, "copy and scan writes overlap")
  `OCX_ASSERT_IMPL(a_k_bound, clk, rst, 1'b1, k <= slots, "more cities placed than free slots")
  `OCX_ASSERT_NEXT(a_vis_hold, clk, rst, cmd.scan && !cp_valid, $stable(visited_map), "visit map changed during scan")

endmodule

FILE: sim/order_crossover_permutation_unit_test.sv
`timescale 1ns / 1ps
// testbench for the order crossover unit: directed tours, then random tours
// results are checked against an in-bench crossover model; depends on ocx_pkg
module order_crossover_permutation_unit_test;
  import ocx_pkg::*;

  localparam int MAX_CITIES  = MAX_CITIES_DEF;
  localparam int ITEM_TARGET = 270;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int TOUR_ROOM   = 72;

  typedef logic [CITY_W-1:0] city_t;
  typedef enum int {PERM_LOW, PERM_WIDE, NOISE} tour_kind_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  ocx_in_t  item = '0;
  logic     busy;
  ocx_out_t result;
  logic     result_valid;

  // crossover model state
  city_t    parent_one[MAX_CITIES];
  city_t    parent_two[MAX_CITIES];
  int       loaded = 0;
  ocx_out_t pending_children[$];

  // stimulus state
  city_t    tour_a[TOUR_ROOM];
  city_t    tour_b[TOUR_ROOM];
  city_t    pool[CITY_COUNT];
  bit       no_idle = 1'b0;
  int       stored_items = 0;
  int       errors = 0;
  int       quiet = 0;
  ocx_out_t want;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  order_crossover_permutation_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid)
  );

  // loads one position; on the closing item builds the child tour
  function automatic void predict_child(input ocx_in_t it);
    city_t    child [MAX_CITIES];
    bit       filled[MAX_CITIES];
    bit       seen  [CITY_COUNT];
    int       n, cs, ce, slots, k, ppos, pos, i;
    bit       bad;
    ocx_out_t r;
    if (loaded < MAX_CITIES) begin
      parent_one[loaded] = it.first_parent_city;
      parent_two[loaded] = it.second_parent_city;
      loaded++;
      stored_items++;
    end
    if (!it.last) return;
    n = loaded;
    loaded = 0;
    cs = it.cut_start;
    ce = it.cut_end;
    bad = !(cs < ce && ce < n);
    for (i = 0; i < CITY_COUNT; i++) seen[i] = 1'b0;
    for (i = 0; i < MAX_CITIES; i++) begin
      filled[i] = 1'b0;
      child[i] = '0;
    end
    if (bad) begin
      for (i = 0; i < n; i++) begin
        child[i] = parent_one[i];
        filled[i] = 1'b1;
      end
    end else begin
      // kept segment from parent one
      for (i = cs; i <= ce; i++) begin
        child[i] = parent_one[i];
        filled[i] = 1'b1;
        seen[parent_one[i]] = 1'b1;
      end
      // cyclic scan of parent two into the free slots after the second cut
      slots = n - (ce - cs + 1);
      k = 0;
      ppos = (ce + 1) % n;
      for (i = 0; i < n; i++) begin
        if (!seen[parent_two[ppos]] && k < slots) begin
          pos = (ce + 1 + k) % n;
          child[pos] = parent_two[ppos];
          filled[pos] = 1'b1;
          k++;
        end
        ppos = (ppos + 1) % n;
      end
    end
    for (i = 0; i < n; i++) begin
      r.child_city = filled[i] ? child[i] : '0;
      r.unfilled   = !filled[i];
      r.bad_cut    = bad;
      r.last_res   = (i == n - 1);
      pending_children.push_back(r);
    end
  endfunction

  // check each child position against the oldest expected one
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_children.size() == 0) begin
        $error("unexpected child position: child_city %0d", result.child_city);
        errors++;
      end else begin
        want = pending_children.pop_front();
        if (result.child_city !== want.child_city) begin
          $error("child_city: expected %0d, got %0d", want.child_city, result.child_city);
          errors++;
        end
        if (result.unfilled !== want.unfilled) begin
          $error("unfilled: expected %0b, got %0b", want.unfilled, result.unfilled);
          errors++;
        end
        if (result.bad_cut !== want.bad_cut) begin
          $error("bad_cut: expected %0b, got %0b", want.bad_cut, result.bad_cut);
          errors++;
        end
        if (result.last_res !== want.last_res) begin
          $error("last_res: expected %0b, got %0b", want.last_res, result.last_res);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or child position
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("order_crossover_permutation_unit test failed");
        $finish;
      end
    end
  end

  // one item, after a random gap; start stays high for a back-to-back item
  task automatic send_item(input ocx_in_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_child(it);
  endtask

  // one tour from tour_a / tour_b; cuts on earlier items are noise
  task automatic send_tour(input int n, input int cs, input int ce);
    ocx_in_t it;
    int      i;
    for (i = 0; i < n; i++) begin
      it.first_parent_city  = tour_a[i];
      it.second_parent_city = tour_b[i];
      it.last      = (i == n - 1);
      it.cut_start = it.last ? city_t'(cs) : city_t'($urandom_range(0, 63));
      it.cut_end   = it.last ? city_t'(ce) : city_t'($urandom_range(0, 63));
      send_item(it);
    end
  endtask

  // hold the sender off until every child position is out
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_children.size() != 0) @(posedge clk);
  endtask

  function automatic void put(input int idx, input int a, input int b);
    tour_a[idx] = city_t'(a);
    tour_b[idx] = city_t'(b);
  endfunction

  // random order of the first m entries of pool
  function automatic void mix_pool(input int m);
    int    i, j;
    city_t t;
    for (i = m - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
  endfunction

  // parents as permutations of one city set, or plain noise
  function automatic void fill_tour(input int n, input tour_kind_t kind);
    int i, m;
    m = (n > CITY_COUNT) ? CITY_COUNT : n;
    for (i = 0; i < CITY_COUNT; i++) pool[i] = city_t'(i);
    if (kind == PERM_WIDE) mix_pool(CITY_COUNT);
    mix_pool(m);
    for (i = 0; i < n; i++)
      tour_a[i] = (i < m && kind != NOISE) ? pool[i] : city_t'($urandom_range(0, 63));
    mix_pool(m);
    for (i = 0; i < n; i++)
      tour_b[i] = (i < m && kind != NOISE) ? pool[i] : city_t'($urandom_range(0, 63));
  endfunction

  // extreme city values with valid cuts
  task automatic test_extremes();
    put(0, 63, 0);
    put(1, 0, 63);
    send_tour(2, 0, 1);
    put(0, 0, 63);
    put(1, 63, 1);
    put(2, 1, 0);
    send_tour(3, 1, 2);
    wait_drained();
  endtask

  // one-city tour with all-ones fields, equal cuts, reversed cuts, cut past end
  task automatic test_bad_cuts();
    put(0, 63, 63);
    send_tour(1, 63, 63);
    put(0, 5, 9);
    put(1, 9, 5);
    put(2, 7, 7);
    send_tour(3, 1, 1);
    send_tour(3, 2, 1);
    send_tour(3, 0, 3);
    wait_drained();
  endtask

  // parent two repeats an outside city (surplus), or yields nothing (unfilled)
  task automatic test_broken_parents();
    int i;
    for (i = 0; i < 5; i++) put(i, i, 7);
    send_tour(5, 1, 2);
    put(0, 0, 1);
    put(1, 1, 2);
    put(2, 2, 1);
    put(3, 3, 2);
    send_tour(4, 1, 2);
    wait_drained();
  endtask

  // a full tour, then one past capacity that closes on a dropped item
  task automatic test_full_and_overflow();
    int cs;
    no_idle = ($urandom_range(0, 1) == 0);
    fill_tour(MAX_CITIES, PERM_WIDE);
    send_tour(MAX_CITIES, $urandom_range(0, 31), $urandom_range(32, 63));
    no_idle = ($urandom_range(0, 1) == 0);
    fill_tour(MAX_CITIES + 2, PERM_LOW);
    cs = $urandom_range(0, MAX_CITIES - 2);
    send_tour(MAX_CITIES + 2, cs, $urandom_range(cs + 1, MAX_CITIES - 1));
    wait_drained();
  endtask

  // mostly well-formed small tours with random content, some noise
  task automatic test_random_tours();
    int         n, cs, ce, pick;
    tour_kind_t kind;
    while (stored_items < ITEM_TARGET) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
      pick = $urandom_range(0, 9);
      kind = (pick < 6) ? PERM_LOW : (pick < 8) ? PERM_WIDE : NOISE;
      fill_tour(n, kind);
      if (n >= 2 && $urandom_range(0, 4) != 0) begin
        cs = $urandom_range(0, n - 2);
        ce = $urandom_range(cs + 1, n - 1);
      end else begin
        cs = $urandom_range(0, 63);
        ce = $urandom_range(0, 63);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      send_tour(n, cs, ce);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_bad_cuts();
    test_broken_parents();
    test_full_and_overflow();
    test_random_tours();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("order_crossover_permutation_unit test passed");
    end else begin
      $display("order_crossover_permutation_unit test failed");
    end
    $finish;
  end

endmodule
